// ===== rtl/core/ljv_pkg.sv =====
// Shared types, constants and arithmetic helpers of the Lennard-Jones Verlet step block.
package ljv_pkg;

  // Sizes
  localparam int MAX_PARTICLES_DEF = 16;
  localparam int IDX_FIELD_W       = 4;
  localparam int POS_W             = 32;
  localparam int LEN_W             = 30;
  localparam int SIG_W             = 60;
  localparam int GAIN_W            = 32;
  localparam int COUNT_W           = 5;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 60;
  localparam int SUM_W             = 64;

  // Shared multiplier: 96 x 64 bit, built from 32 x 32 partial products
  localparam int MUL_A_W = 96;
  localparam int MUL_B_W = 64;
  localparam int MUL_P_W = 160;

  // Divider widths
  localparam int RATIO_NUM_W = 92;
  localparam int WRAP_NUM_W  = 64;

  // Register reset values
  localparam logic [COUNT_W-1:0] COUNT_RST = 5'd9;
  localparam logic [LEN_W-1:0]   WIDTH_RST = 30'd77822202;
  localparam logic [LEN_W-1:0]   HEIGHT_RST = 30'd70871617;
  localparam logic [SIG_W-1:0]   SIGMA_RST = 60'd636056365000000;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 32'd2533900000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_SQ       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LJ_GAIN        = 3'd4;

  // Request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    P_START_I,
    P_LOAD_I,
    P_RD_J,
    P_DIFF,
    P_MODW,
    P_SQX,
    P_SQY,
    P_RATIO,
    P_U2,
    P_U4,
    P_U6,
    P_U7,
    P_GW,
    P_TX,
    P_TY,
    P_NEXT_J,
    P_NEXT_I,
    U_RD,
    U_CALC,
    U_WRAP,
    U_OUT
  } ljv_state_t;

  // 64-bit signed saturating add
  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // 64-bit signed saturating subtract
  function automatic logic signed [63:0] sat_sub64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // Clamp a 64-bit signed value into 32 bits
  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Q32.32 product taken from a full product, saturated to 64 bits
  function automatic logic [63:0] fix_q32(logic [MUL_P_W-1:0] p);
    if (|p[127:96]) return '1;
    return p[95:32];
  endfunction

endpackage

// ===== rtl/core/ljv_if.sv =====
// Request, result and configuration channel interfaces of the Lennard-Jones step block.
interface ljv_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic [ljv_pkg::IDX_FIELD_W-1:0]      particle_index;
  logic signed [ljv_pkg::POS_W-1:0]     load_x;
  logic signed [ljv_pkg::POS_W-1:0]     load_y;
  logic signed [ljv_pkg::POS_W-1:0]     load_prev_x;
  logic signed [ljv_pkg::POS_W-1:0]     load_prev_y;

  modport source(output valid, req_type, particle_index, load_x, load_y,
                 load_prev_x, load_prev_y, input ready);
  modport sink(input valid, req_type, particle_index, load_x, load_y,
               load_prev_x, load_prev_y, output ready);
endinterface

interface ljv_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [ljv_pkg::IDX_FIELD_W-1:0]      out_index;
  logic signed [ljv_pkg::POS_W-1:0]     out_x;
  logic signed [ljv_pkg::POS_W-1:0]     out_y;
  logic                                 last;

  modport source(output valid, out_index, out_x, out_y, last, input ready);
  modport sink(input valid, out_index, out_x, out_y, last, output ready);
endinterface

interface ljv_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [ljv_pkg::CFG_IDX_W-1:0]        index;
  logic [ljv_pkg::CFG_DATA_W-1:0]       data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/ljv_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ljv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ljv_div.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
module ljv_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // next partial remainder and quotient bit
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    fits  = trial >= {1'b0, den_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/ljv_mul.sv =====
// Sequential 96 x 64 bit multiplier over one 32 x 32 partial product per cycle.
module ljv_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ljv_pkg::MUL_A_W-1:0] a,
  input  logic [ljv_pkg::MUL_B_W-1:0] b,
  output logic                        done,
  output logic [ljv_pkg::MUL_P_W-1:0] prod
);

  localparam logic [2:0] LAST_K = 3'd6;

  logic                        busy;
  logic                        have_pp;
  logic [2:0]                  k;
  logic [ljv_pkg::MUL_A_W-1:0] a_r;
  logic [ljv_pkg::MUL_B_W-1:0] b_r;
  logic [63:0]                 pp;
  logic [1:0]                  sh;
  logic [31:0]                 a_chunk;
  logic [31:0]                 b_chunk;
  logic [ljv_pkg::MUL_P_W-1:0] pp_shifted;

  // operand chunk selection: k = 2*a_chunk + b_chunk
  always_comb begin
    a_chunk    = a_r[32*k[2:1] +: 32];
    b_chunk    = b_r[32*k[0] +: 32];
    pp_shifted = {96'b0, pp} << {sh, 5'b0};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      have_pp <= 1'b0;
      k       <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        have_pp <= 1'b0;
        k       <= '0;
      end else if (busy) begin
        if (k == LAST_K) begin
          busy    <= 1'b0;
          have_pp <= 1'b0;
          done    <= 1'b1;
        end else begin
          have_pp <= 1'b1;
          k       <= k + 3'd1;
        end
      end
    end
  end

  // partial product register and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      if (have_pp) begin
        prod <= prod + pp_shifted;
      end
      if (k != LAST_K) begin
        pp <= a_chunk * b_chunk;
        sh <= k[2:1] + {1'b0, k[0]};
      end
    end
  end

endmodule

// ===== rtl/core/lennard_jones_verlet_step_top.sv =====
// Top level of the two-dimensional Lennard-Jones position Verlet step block.
//
// Channels: req carries load and step requests, rsp carries one new position
// per particle on each step, cfg writes the five configuration registers
// (count, box width, box height, sigma squared, gain); cfg is always ready.
// A load request writes one particle's current and previous position and
// returns nothing. A step request first sums the pair forces of
// every particle against all others, then updates, wraps and reports each
// particle in index order with last set on the final one.
// The block takes one request at a time. For each ordered pair with nonzero
// distance a step runs a minimum-image remainder, a sigma^2/r^2 divide and
// nine passes of the shared multiplier; the update of each particle runs one
// wrap remainder. State lives in three one-port-read RAMs.
// Reset: registers take their default values, the block is idle; positions
// are undefined until loaded. When the receiver stalls, the block holds the
// current result and waits before the next particle.
module lennard_jones_verlet_step_top #(
  parameter int MAX_PARTICLES = ljv_pkg::MAX_PARTICLES_DEF
) (
  input logic clk,
  input logic rst,
  ljv_req_if.sink   req,
  ljv_rsp_if.source rsp,
  ljv_cfg_if.sink   cfg
);

  localparam int IDX_W = $clog2(MAX_PARTICLES);

  ljv_pkg::ljv_state_t state, state_next;

  // configuration registers
  logic [ljv_pkg::COUNT_W-1:0] count_reg;
  logic [ljv_pkg::LEN_W-1:0]   box_w;
  logic [ljv_pkg::LEN_W-1:0]   box_h;
  logic [ljv_pkg::SIG_W-1:0]   sig_sq;
  logic [ljv_pkg::GAIN_W-1:0]  gain;

  logic [IDX_W-1:0]            last_idx;
  logic [ljv_pkg::LEN_W-1:0]   len_x;
  logic [ljv_pkg::LEN_W-1:0]   len_y;

  // RAM ports
  logic                        pos_we, prev_we, sum_we;
  logic [IDX_W-1:0]            waddr, raddr;
  logic [63:0]                 pos_wdata, prev_wdata;
  logic [127:0]                sum_wdata;
  logic [63:0]                 pos_rd, prev_rd;
  logic [127:0]                sum_rd;

  // arithmetic units
  logic                        mul_start, mul_done;
  logic [ljv_pkg::MUL_A_W-1:0] mul_a;
  logic [ljv_pkg::MUL_B_W-1:0] mul_b;
  logic [ljv_pkg::MUL_P_W-1:0] mul_prod;
  logic                        divxy_start, divx_done, divy_done;
  logic [ljv_pkg::WRAP_NUM_W-1:0] divx_num, divy_num;
  logic [ljv_pkg::LEN_W-1:0]   divx_rem, divy_rem;
  logic                        divr_start, divr_done;
  logic [ljv_pkg::RATIO_NUM_W-1:0] divr_quo;
  logic [ljv_pkg::SIG_W-1:0]   divr_den;

  // datapath registers
  logic [IDX_W-1:0]            i_idx, j_idx;
  logic [31:0]                 ci_x, ci_y;
  logic                        dneg_x, dneg_y;
  logic [ljv_pkg::LEN_W-1:0]   adx, ady;
  logic [59:0]                 sq_x;
  logic [63:0]                 u, u2, u4;
  logic                        pneg;
  logic [95:0]                 w;
  logic signed [63:0]          sx, sy;
  logic signed [63:0]          n_x, n_y;
  logic [31:0]                 c_x, c_y;
  logic                        out_valid;
  logic [ljv_pkg::IDX_FIELD_W-1:0] out_index;
  logic [31:0]                 out_x, out_y;
  logic                        out_last;

  // combinational datapath
  logic                        req_acc, rsp_acc, load_ok;
  logic signed [32:0]          d_x, d_y;
  logic [32:0]                 ad_x, ad_y;
  logic                        hh_x, hh_y;
  logic [ljv_pkg::LEN_W-1:0]   mg_x, mg_y;
  logic                        ng_x, ng_y;
  logic [63:0]                 u_c, fixp, half, pmag_c;
  logic                        pneg_c;
  logic [47:0]                 tmag;
  logic                        tneg;
  logic signed [63:0]          term64;
  logic signed [63:0]          cc_x, cc_y, nc_x, nc_y;
  logic [63:0]                 nabs_x, nabs_y;
  logic [ljv_pkg::LEN_W-1:0]   rmod_x, rmod_y;
  logic signed [63:0]          wr_x, wr_y;
  logic signed [31:0]          pn_x, pn_y;

  assign req_acc = req.valid && req.ready;
  assign rsp_acc = rsp.valid && rsp.ready;
  assign load_ok = (int'(req.particle_index) < MAX_PARTICLES);

  // effective count and box sizes
  always_comb begin
    if (count_reg == '0) begin
      last_idx = '0;
    end else if (int'(count_reg) > MAX_PARTICLES) begin
      last_idx = IDX_W'(MAX_PARTICLES - 1);
    end else begin
      last_idx = IDX_W'(count_reg - 5'd1);
    end
    len_x = (box_w == '0) ? ljv_pkg::LEN_W'(1) : box_w;
    len_y = (box_h == '0) ? ljv_pkg::LEN_W'(1) : box_h;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= ljv_pkg::COUNT_RST;
      box_w     <= ljv_pkg::WIDTH_RST;
      box_h     <= ljv_pkg::HEIGHT_RST;
      sig_sq    <= ljv_pkg::SIGMA_RST;
      gain      <= ljv_pkg::GAIN_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        ljv_pkg::REG_PARTICLE_COUNT: count_reg <= cfg.data[ljv_pkg::COUNT_W-1:0];
        ljv_pkg::REG_BOX_WIDTH:      box_w     <= cfg.data[ljv_pkg::LEN_W-1:0];
        ljv_pkg::REG_BOX_HEIGHT:     box_h     <= cfg.data[ljv_pkg::LEN_W-1:0];
        ljv_pkg::REG_SIGMA_SQ:       sig_sq    <= cfg.data[ljv_pkg::SIG_W-1:0];
        ljv_pkg::REG_LJ_GAIN:        gain      <= cfg.data[ljv_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end
  assign cfg.ready = 1'b1;

  // pair distance: raw difference, then minimum image from the remainder
  always_comb begin
    d_x  = {pos_rd[63], pos_rd[63:32]} - {ci_x[31], ci_x};
    d_y  = {pos_rd[31], pos_rd[31:0]} - {ci_y[31], ci_y};
    ad_x = d_x[32] ? 33'(-d_x) : 33'(d_x);
    ad_y = d_y[32] ? 33'(-d_y) : 33'(d_y);
    hh_x = {divx_rem, 1'b0} >= {1'b0, len_x};
    hh_y = {divy_rem, 1'b0} >= {1'b0, len_y};
    mg_x = hh_x ? len_x - divx_rem : divx_rem;
    mg_y = hh_y ? len_y - divy_rem : divy_rem;
    ng_x = hh_x ? !dneg_x : dneg_x;
    ng_y = hh_y ? !dneg_y : dneg_y;
  end

  // potential polynomial and pair term
  always_comb begin
    u_c    = (|divr_quo[91:64]) ? '1 : divr_quo[63:0];
    fixp   = ljv_pkg::fix_q32(mul_prod);
    half   = u4 >> 1;
    pneg_c = fixp < half;
    pmag_c = pneg_c ? half - fixp : fixp - half;
    tmag   = mul_prod[127:80];
    tneg   = (pneg == ((state == ljv_pkg::P_TX) ? dneg_x : dneg_y));
    term64 = tneg ? -$signed({16'b0, tmag}) : $signed({16'b0, tmag});
  end

  // Verlet update and box wrap
  always_comb begin
    cc_x   = {{32{pos_rd[63]}}, pos_rd[63:32]};
    cc_y   = {{32{pos_rd[31]}}, pos_rd[31:0]};
    nc_x   = ljv_pkg::sat_add64((cc_x <<< 1) - $signed({{32{prev_rd[63]}}, prev_rd[63:32]}),
                                $signed(sum_rd[127:64]));
    nc_y   = ljv_pkg::sat_add64((cc_y <<< 1) - $signed({{32{prev_rd[31]}}, prev_rd[31:0]}),
                                $signed(sum_rd[63:0]));
    nabs_x = nc_x[63] ? (~nc_x + 64'd1) : nc_x;
    nabs_y = nc_y[63] ? (~nc_y + 64'd1) : nc_y;
    // negative values take the floored remainder
    rmod_x = (n_x[63] && divx_rem != '0) ? len_x - divx_rem : divx_rem;
    rmod_y = (n_y[63] && divy_rem != '0) ? len_y - divy_rem : divy_rem;
    wr_x   = ({rmod_x, 1'b0} < {1'b0, len_x}) ? $signed({34'b0, rmod_x})
             : $signed({34'b0, rmod_x}) - $signed({34'b0, len_x});
    wr_y   = ({rmod_y, 1'b0} < {1'b0, len_y}) ? $signed({34'b0, rmod_y})
             : $signed({34'b0, rmod_y}) - $signed({34'b0, len_y});
    pn_x   = ljv_pkg::clamp32(ljv_pkg::sat_sub64(wr_x,
               ljv_pkg::sat_sub64(n_x, $signed({{32{c_x[31]}}, c_x}))));
    pn_y   = ljv_pkg::clamp32(ljv_pkg::sat_sub64(wr_y,
               ljv_pkg::sat_sub64(n_y, $signed({{32{c_y[31]}}, c_y}))));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ljv_pkg::S_IDLE:    if (req_acc && req.req_type == ljv_pkg::REQ_STEP) begin
                            state_next = ljv_pkg::P_START_I;
                          end
      ljv_pkg::P_START_I: state_next = ljv_pkg::P_LOAD_I;
      ljv_pkg::P_LOAD_I:  state_next = ljv_pkg::P_RD_J;
      ljv_pkg::P_RD_J:    state_next = (j_idx == i_idx) ? ljv_pkg::P_NEXT_J : ljv_pkg::P_DIFF;
      ljv_pkg::P_DIFF:    state_next = ljv_pkg::P_MODW;
      ljv_pkg::P_MODW:    if (divx_done) begin
                            state_next = (mg_x == '0 && mg_y == '0) ? ljv_pkg::P_NEXT_J
                                                                    : ljv_pkg::P_SQX;
                          end
      ljv_pkg::P_SQX:     if (mul_done) state_next = ljv_pkg::P_SQY;
      ljv_pkg::P_SQY:     if (mul_done) state_next = ljv_pkg::P_RATIO;
      ljv_pkg::P_RATIO:   if (divr_done) state_next = ljv_pkg::P_U2;
      ljv_pkg::P_U2:      if (mul_done) state_next = ljv_pkg::P_U4;
      ljv_pkg::P_U4:      if (mul_done) state_next = ljv_pkg::P_U6;
      ljv_pkg::P_U6:      if (mul_done) state_next = ljv_pkg::P_U7;
      ljv_pkg::P_U7:      if (mul_done) state_next = ljv_pkg::P_GW;
      ljv_pkg::P_GW:      if (mul_done) state_next = ljv_pkg::P_TX;
      ljv_pkg::P_TX:      if (mul_done) state_next = ljv_pkg::P_TY;
      ljv_pkg::P_TY:      if (mul_done) state_next = ljv_pkg::P_NEXT_J;
      ljv_pkg::P_NEXT_J:  state_next = (j_idx == last_idx) ? ljv_pkg::P_NEXT_I
                                                           : ljv_pkg::P_RD_J;
      ljv_pkg::P_NEXT_I:  state_next = (i_idx == last_idx) ? ljv_pkg::U_RD
                                                           : ljv_pkg::P_START_I;
      ljv_pkg::U_RD:      state_next = ljv_pkg::U_CALC;
      ljv_pkg::U_CALC:    state_next = ljv_pkg::U_WRAP;
      ljv_pkg::U_WRAP:    if (divx_done) state_next = ljv_pkg::U_OUT;
      ljv_pkg::U_OUT:     if (rsp_acc) begin
                            state_next = (i_idx == last_idx) ? ljv_pkg::S_IDLE : ljv_pkg::U_RD;
                          end
      default:            state_next = ljv_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ljv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control outputs: RAM ports, unit starts and operands
  always_comb begin
    req.ready   = (state == ljv_pkg::S_IDLE);
    raddr       = (state == ljv_pkg::P_RD_J) ? j_idx : i_idx;
    waddr       = (state == ljv_pkg::S_IDLE) ? IDX_W'(req.particle_index) : i_idx;
    pos_we      = 1'b0;
    prev_we     = 1'b0;
    sum_we      = 1'b0;
    pos_wdata   = {wr_x[31:0], wr_y[31:0]};
    prev_wdata  = {pn_x, pn_y};
    sum_wdata   = {sx, sy};
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    divxy_start = 1'b0;
    divx_num    = {31'b0, ad_x};
    divy_num    = {31'b0, ad_y};
    divr_start  = 1'b0;
    divr_den    = sq_x + mul_prod[59:0];
    case (state)
      ljv_pkg::S_IDLE: begin
        if (req_acc && req.req_type == ljv_pkg::REQ_LOAD && load_ok) begin
          pos_we  = 1'b1;
          prev_we = 1'b1;
        end
        pos_wdata  = {req.load_x, req.load_y};
        prev_wdata = {req.load_prev_x, req.load_prev_y};
      end
      ljv_pkg::P_DIFF: divxy_start = 1'b1;
      ljv_pkg::P_MODW: begin
        mul_start = divx_done && !(mg_x == '0 && mg_y == '0);
        mul_a     = {66'b0, mg_x};
        mul_b     = {34'b0, mg_x};
      end
      ljv_pkg::P_SQX: begin
        mul_start = mul_done;
        mul_a     = {66'b0, ady};
        mul_b     = {34'b0, ady};
      end
      ljv_pkg::P_SQY:   divr_start = mul_done;
      ljv_pkg::P_RATIO: begin
        mul_start = divr_done;
        mul_a     = {32'b0, u_c};
        mul_b     = u_c;
      end
      ljv_pkg::P_U2: begin
        mul_start = mul_done;
        mul_a     = {32'b0, fixp};
        mul_b     = fixp;
      end
      ljv_pkg::P_U4: begin
        mul_start = mul_done;
        mul_a     = {32'b0, fixp};
        mul_b     = u2;
      end
      ljv_pkg::P_U6: begin
        mul_start = mul_done;
        mul_a     = {32'b0, fixp};
        mul_b     = u;
      end
      ljv_pkg::P_U7: begin
        mul_start = mul_done;
        mul_a     = {32'b0, pmag_c};
        mul_b     = {32'b0, gain};
      end
      ljv_pkg::P_GW: begin
        mul_start = mul_done;
        mul_a     = mul_prod[95:0];
        mul_b     = {34'b0, adx};
      end
      ljv_pkg::P_TX: begin
        mul_start = mul_done;
        mul_a     = w;
        mul_b     = {34'b0, ady};
      end
      ljv_pkg::P_NEXT_J: sum_we = (j_idx == last_idx);
      ljv_pkg::U_CALC: begin
        divxy_start = 1'b1;
        divx_num    = nabs_x;
        divy_num    = nabs_y;
      end
      ljv_pkg::U_WRAP: begin
        pos_we  = divx_done;
        prev_we = divx_done;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ljv_pkg::S_IDLE:   if (req_acc && req.req_type == ljv_pkg::REQ_STEP) i_idx <= '0;
      ljv_pkg::P_LOAD_I: begin
        ci_x  <= pos_rd[63:32];
        ci_y  <= pos_rd[31:0];
        j_idx <= '0;
        sx    <= '0;
        sy    <= '0;
      end
      ljv_pkg::P_DIFF: begin
        dneg_x <= d_x[32];
        dneg_y <= d_y[32];
      end
      ljv_pkg::P_MODW: if (divx_done) begin
        adx    <= mg_x;
        ady    <= mg_y;
        dneg_x <= ng_x;
        dneg_y <= ng_y;
      end
      ljv_pkg::P_SQX:   if (mul_done) sq_x <= mul_prod[59:0];
      ljv_pkg::P_RATIO: if (divr_done) u <= u_c;
      ljv_pkg::P_U2:    if (mul_done) u2 <= fixp;
      ljv_pkg::P_U4:    if (mul_done) u4 <= fixp;
      ljv_pkg::P_U7:    if (mul_done) pneg <= pneg_c;
      ljv_pkg::P_GW:    if (mul_done) w <= mul_prod[95:0];
      ljv_pkg::P_TX:    if (mul_done) sx <= ljv_pkg::sat_add64(sx, term64);
      ljv_pkg::P_TY:    if (mul_done) sy <= ljv_pkg::sat_add64(sy, term64);
      ljv_pkg::P_NEXT_J: if (j_idx != last_idx) j_idx <= j_idx + 1'b1;
      ljv_pkg::P_NEXT_I: i_idx <= (i_idx == last_idx) ? '0 : i_idx + 1'b1;
      ljv_pkg::U_CALC: begin
        n_x <= nc_x;
        n_y <= nc_y;
        c_x <= pos_rd[63:32];
        c_y <= pos_rd[31:0];
      end
      ljv_pkg::U_WRAP: if (divx_done) begin
        out_x     <= wr_x[31:0];
        out_y     <= wr_y[31:0];
        out_index <= ljv_pkg::IDX_FIELD_W'(i_idx);
        out_last  <= (i_idx == last_idx);
      end
      ljv_pkg::U_OUT: if (rsp_acc && i_idx != last_idx) i_idx <= i_idx + 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ljv_pkg::U_WRAP && divx_done) begin
      out_valid <= 1'b1;
    end else if (rsp_acc) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.out_index = out_index;
  assign rsp.out_x     = out_x;
  assign rsp.out_y     = out_y;
  assign rsp.last      = out_last;

  // state memories: positions, previous positions, force sums
  ljv_ram #(.WIDTH(64), .DEPTH(MAX_PARTICLES)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(waddr), .wdata(pos_wdata),
    .raddr(raddr), .rdata(pos_rd)
  );

  ljv_ram #(.WIDTH(64), .DEPTH(MAX_PARTICLES)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(waddr), .wdata(prev_wdata),
    .raddr(raddr), .rdata(prev_rd)
  );

  ljv_ram #(.WIDTH(128), .DEPTH(MAX_PARTICLES)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(i_idx), .wdata(sum_wdata),
    .raddr(raddr), .rdata(sum_rd)
  );

  // shared multiplier
  ljv_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  // per-axis remainder units (minimum image and box wrap)
  ljv_div #(.NUM_W(ljv_pkg::WRAP_NUM_W), .DEN_W(ljv_pkg::LEN_W)) u_div_x (
    .clk(clk), .rst(rst), .start(divxy_start), .num(divx_num), .den(len_x),
    .done(divx_done), .quo(), .rem(divx_rem)
  );

  ljv_div #(.NUM_W(ljv_pkg::WRAP_NUM_W), .DEN_W(ljv_pkg::LEN_W)) u_div_y (
    .clk(clk), .rst(rst), .start(divxy_start), .num(divy_num), .den(len_y),
    .done(divy_done), .quo(), .rem(divy_rem)
  );

  // sigma^2 / r^2 ratio divider
  ljv_div #(.NUM_W(ljv_pkg::RATIO_NUM_W), .DEN_W(ljv_pkg::SIG_W)) u_div_r (
    .clk(clk), .rst(rst), .start(divr_start), .num({sig_sq, 32'b0}), .den(divr_den),
    .done(divr_done), .quo(divr_quo), .rem()
  );

  // checks
  a_rsp_only_in_out: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> state == ljv_pkg::U_OUT)
    else $error("result valid outside output state");

  a_no_req_while_rsp: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid)
    else $error("request taken while a result is pending");

  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.last) |-> i_idx == last_idx)
    else $error("last flag on wrong particle");

  a_axes_in_step: assert property (@(posedge clk) disable iff (rst)
    divx_done |-> divy_done)
    else $error("axis remainder units out of step");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench of the Lennard-Jones Verlet step block.
`timescale 1ns / 1ps

module tb;
  import ljv_pkg::*;

  localparam int NPART = MAX_PARTICLES_DEF;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  typedef struct {
    logic [IDX_FIELD_W-1:0] idx;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic last;
  } position_t;

  logic clk;
  logic rst;
  ljv_req_if req_ch();
  ljv_rsp_if rsp_ch();
  ljv_cfg_if cfg_ch();

  lennard_jones_verlet_step_top uut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
  );

  // Predictor state
  logic signed [POS_W-1:0] pos_x[NPART], pos_y[NPART], old_x[NPART], old_y[NPART];
  logic [COUNT_W-1:0] m_count;
  logic [LEN_W-1:0] m_width, m_height;
  logic [SIG_W-1:0] m_sigma;
  logic [GAIN_W-1:0] m_gain;

  position_t pos_expect_q[$];
  int fail_count = 0;
  longint cycle_count = 0;
  int burst_left = 0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_mode = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lennard_jones_verlet_step_top: mismatch");
      $finish;
    end
  end

  // Arithmetic of the step
  function automatic longint sat_add(longint a, longint b);
    logic signed [64:0] s;
    s = a;
    s = s + b;
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    logic signed [64:0] s;
    s = a;
    s = s - b;
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] to_pos(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint nearest_image(longint d, longint len);
    longint ad, q, r;
    ad = d < 0 ? -d : d;
    q = (2 * ad + len) / (2 * len);
    r = ad - q * len;
    return d < 0 ? -r : r;
  endfunction

  function automatic longint into_box(longint n, longint len);
    longint r;
    r = n % len;
    if (r < 0) r += len;
    return (2 * r < len) ? r : r - len;
  endfunction

  function automatic logic [63:0] q32_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    if (|p[127:96]) return '1;
    return p[95:32];
  endfunction

  function automatic logic [63:0] sigma_over_r2(logic [63:0] den);
    logic [95:0] q;
    q = {4'b0, m_sigma, 32'b0} / {32'b0, den};
    if (|q[95:64]) return '1;
    return q[63:0];
  endfunction

  function automatic longint force_term(logic [63:0] pmag, bit pneg, longint d);
    logic [191:0] full;
    logic [111:0] hi;
    logic [63:0] ad;
    longint mag;
    ad = d < 0 ? -d : d;
    full = {128'b0, pmag} * {160'b0, m_gain};
    full = full * {128'b0, ad};
    hi = full[191:80];
    mag = (|hi[111:63]) ? S64_MAX : longint'(hi[62:0]);
    return (pneg == (d < 0)) ? -mag : mag;
  endfunction

  task automatic move_axis(ref logic signed [31:0] c_pos, ref logic signed [31:0] p_pos,
                           input longint sum, input longint len);
    longint c, n, wr;
    c = c_pos;
    n = sat_add(2 * c - longint'(p_pos), sum);
    wr = into_box(n, len);
    p_pos = to_pos(sat_sub(wr, sat_sub(n, c)));
    c_pos = wr[31:0];
  endtask

  // Advance the predicted particle set by one step and queue its positions
  task automatic predict_step();
    int cnt;
    longint w, h, dx, dy, r2;
    longint fx[NPART], fy[NPART];
    logic [63:0] u, u2, u4, u7, half, pmag;
    bit pneg;
    position_t e;
    cnt = m_count;
    if (cnt < 1) cnt = 1;
    if (cnt > NPART) cnt = NPART;
    w = m_width ? longint'(m_width) : 1;
    h = m_height ? longint'(m_height) : 1;
    for (int i = 0; i < cnt; i++) begin
      fx[i] = 0;
      fy[i] = 0;
      for (int j = 0; j < cnt; j++) begin
        if (j == i) continue;
        dx = nearest_image(longint'(pos_x[j]) - longint'(pos_x[i]), w);
        dy = nearest_image(longint'(pos_y[j]) - longint'(pos_y[i]), h);
        if (dx == 0 && dy == 0) continue;
        r2 = dx * dx + dy * dy;
        u = sigma_over_r2(r2);
        u2 = q32_mul(u, u);
        u4 = q32_mul(u2, u2);
        u7 = q32_mul(q32_mul(u4, u2), u);
        half = u4 >> 1;
        pneg = u7 < half;
        pmag = pneg ? half - u7 : u7 - half;
        fx[i] = sat_add(fx[i], force_term(pmag, pneg, dx));
        fy[i] = sat_add(fy[i], force_term(pmag, pneg, dy));
      end
    end
    for (int i = 0; i < cnt; i++) begin
      move_axis(pos_x[i], old_x[i], fx[i], w);
      move_axis(pos_y[i], old_y[i], fy[i], h);
      e.idx = i;
      e.x = pos_x[i];
      e.y = pos_y[i];
      e.last = (i == cnt - 1);
      pos_expect_q.push_back(e);
    end
  endtask

  // Receiver ready pattern, with a long hold-off on demand
  always @(negedge clk) begin
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        2: rsp_ch.ready <= ($urandom_range(0, 9) < 4);
        default: rsp_ch.ready <= cycle_count[0];
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    position_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pos_expect_q.size() == 0) begin
        $error("unexpected result: index %0d x %0d y %0d", rsp_ch.out_index,
               rsp_ch.out_x, rsp_ch.out_y);
        fail_count++;
      end else begin
        e = pos_expect_q.pop_front();
        if (rsp_ch.out_index !== e.idx) begin
          $error("out_index: expected %0d actual %0d", e.idx, rsp_ch.out_index);
          fail_count++;
        end
        if (rsp_ch.out_x !== e.x) begin
          $error("out_x: expected %0d actual %0d", e.x, rsp_ch.out_x);
          fail_count++;
        end
        if (rsp_ch.out_y !== e.y) begin
          $error("out_y: expected %0d actual %0d", e.y, rsp_ch.out_y);
          fail_count++;
        end
        if (rsp_ch.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, rsp_ch.last);
          fail_count++;
        end
      end
    end
  end

  // Send one request; valid stays high for a following request in the burst
  task automatic send_req(logic kind, logic [3:0] idx, logic signed [31:0] x,
                          logic signed [31:0] y, logic signed [31:0] ox,
                          logic signed [31:0] oy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.particle_index <= idx;
    req_ch.load_x <= x;
    req_ch.load_y <= y;
    req_ch.load_prev_x <= ox;
    req_ch.load_prev_y <= oy;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (kind == REQ_STEP) begin
      predict_step();
    end else begin
      pos_x[idx] = x;
      pos_y[idx] = y;
      old_x[idx] = ox;
      old_y[idx] = oy;
    end
  endtask

  task automatic send_step();
    send_req(REQ_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Stop requests and wait until every queued position has come back
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (pos_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_PARTICLE_COUNT: m_count = data[COUNT_W-1:0];
      REG_BOX_WIDTH:      m_width = data[LEN_W-1:0];
      REG_BOX_HEIGHT:     m_height = data[LEN_W-1:0];
      REG_SIGMA_SQ:       m_sigma = data[SIG_W-1:0];
      REG_LJ_GAIN:        m_gain = data[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] in_box(logic [LEN_W-1:0] len);
    longint l;
    l = len ? longint'(len) : 1;
    return longint'($urandom_range(0, l - 1)) - l / 2;
  endfunction

  // Load extremes into the first slots and in-box positions into the rest, then step with the reset settings
  task automatic test_reset_defaults();
    send_req(REQ_LOAD, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_req(REQ_LOAD, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_req(REQ_LOAD, 2, 0, 0, -1, 1);
    send_req(REQ_LOAD, 3, 0, 0, 0, 0);
    for (int i = 4; i < NPART; i++)
      send_req(REQ_LOAD, i, in_box(m_width), in_box(m_height), in_box(m_width),
               in_box(m_height));
    send_step();
  endtask

  // Count of zero and above the maximum, zero box, register beyond the list
  task automatic test_register_edges();
    write_reg(REG_UNUSED, {CFG_DATA_W{1'b1}});
    write_reg(REG_PARTICLE_COUNT, 60'hFFF_FFFF_FFFF_FFE0);
    send_step();
    write_reg(REG_BOX_WIDTH, 60'hFFF_FFFF_C000_0000);
    write_reg(REG_BOX_HEIGHT, 0);
    write_reg(REG_PARTICLE_COUNT, 31);
    send_step();
    write_reg(REG_BOX_WIDTH, 30'h3FFF_FFFF);
    write_reg(REG_BOX_HEIGHT, 30'h3FFF_FFFF);
    write_reg(REG_PARTICLE_COUNT, 16);
    send_step();
    write_reg(REG_PARTICLE_COUNT, 3);
    write_reg(REG_SIGMA_SQ, {CFG_DATA_W{1'b1}});
    write_reg(REG_LJ_GAIN, 32'hFFFF_FFFF);
    send_req(REQ_LOAD, 1, 1, 0, 0, 0);
    send_step();
    write_reg(REG_SIGMA_SQ, 1);
    write_reg(REG_LJ_GAIN, 0);
    send_step();
    write_reg(REG_SIGMA_SQ, SIGMA_RST);
    write_reg(REG_LJ_GAIN, GAIN_RST);
    write_reg(REG_BOX_WIDTH, 1);
    write_reg(REG_BOX_HEIGHT, 1);
    send_step();
  endtask

  // Block fills while the receiver holds off, then the sender waits it out
  task automatic test_backpressure();
    write_reg(REG_BOX_WIDTH, WIDTH_RST);
    write_reg(REG_BOX_HEIGHT, HEIGHT_RST);
    write_reg(REG_PARTICLE_COUNT, 5);
    @(negedge clk);
    hold_req = 4000;
    send_step();
    for (int i = 0; i < 4; i++)
      send_req(REQ_LOAD, i, in_box(m_width), in_box(m_height), in_box(m_width),
               in_box(m_height));
    send_step();
    drain();
  endtask

  // Random phases: new settings, then loads with steps among them
  task automatic test_random();
    logic [3:0] idx;
    logic signed [31:0] x, y;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_PARTICLE_COUNT, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(2, 5));
      case ($urandom_range(0, 3))
        0: write_reg(REG_BOX_WIDTH, 1);
        1: write_reg(REG_BOX_WIDTH, 30'h3FFF_FFFF);
        default: write_reg(REG_BOX_WIDTH, {$urandom, $urandom});
      endcase
      write_reg(REG_BOX_HEIGHT, ($urandom_range(0, 3) == 0) ? 30'h3FFF_FFFF :
                                {$urandom, $urandom});
      case ($urandom_range(0, 2))
        0: write_reg(REG_SIGMA_SQ, {$urandom, $urandom});
        1: write_reg(REG_SIGMA_SQ, 64'(SIGMA_RST) * $urandom_range(1, 64));
        default: write_reg(REG_SIGMA_SQ, $urandom_range(1, 1 << 20) * 64'd1000000);
      endcase
      write_reg(REG_LJ_GAIN, $urandom);
      for (int k = 0; k < 55; k++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_step();
        end else begin
          idx = $urandom;
          if ($urandom_range(0, 9) == 0) begin
            send_req(REQ_LOAD, idx, $urandom, $urandom, $urandom, $urandom);
          end else begin
            x = in_box(m_width);
            y = in_box(m_height);
            send_req(REQ_LOAD, idx, x, y, x + $signed($urandom_range(0, 2000)) - 1000,
                     y + $signed($urandom_range(0, 2000)) - 1000);
          end
        end
      end
      send_step();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.particle_index = '0;
    req_ch.load_x = '0;
    req_ch.load_y = '0;
    req_ch.load_prev_x = '0;
    req_ch.load_prev_y = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    m_count = COUNT_RST;
    m_width = WIDTH_RST;
    m_height = HEIGHT_RST;
    m_sigma = SIGMA_RST;
    m_gain = GAIN_RST;
    for (int i = 0; i < NPART; i++) begin
      pos_x[i] = 0;
      pos_y[i] = 0;
      old_x[i] = 0;
      old_y[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_register_edges();
    test_backpressure();
    test_random();

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pos_expect_q.size() == 0) begin
      $display("lennard_jones_verlet_step_top: match");
    end else begin
      $display("lennard_jones_verlet_step_top: mismatch");
    end
    $finish;
  end

endmodule
